// ----- hw/rtl/pru_pkg.sv -----
// ----------------------------------------------------------------------------
// pru_pkg
// Shared widths, codes and the job descriptor of the pixel upscaler.
// ----------------------------------------------------------------------------
package pru_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_SCALE  = 32;
    localparam int MAX_HEIGHT = 4096;

    localparam int SCALE_W  = 6;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;
    localparam int CFG_W    = 13;
    localparam int CIDX_W   = 2;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int COPY_W   = 5;
    localparam int ROW_W    = 12;
    localparam int RGB_W    = 24;
    localparam int STAT_W   = 2;

    localparam logic [CIDX_W-1:0] REG_SCALE  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic OP_PIXEL  = 1'b0;
    localparam logic OP_REPLAY = 1'b1;

    localparam logic [STAT_W-1:0] ST_PIXEL  = 2'd0;
    localparam logic [STAT_W-1:0] ST_PAD    = 2'd1;
    localparam logic [STAT_W-1:0] ST_REJECT = 2'd2;

    typedef struct packed {
        logic               err;
        logic               use_mem;
        logic [RGB_W-1:0]   pixel;
        logic [SCALE_W-1:0] copies;
        logic [1:0]         pad;
        logic               row_done;
        logic               frame_done;
    } job_t;

endpackage

// ----- hw/rtl/pixel_replicating_upscaler.sv -----
// ----------------------------------------------------------------------------
// pixel_replicating_upscaler
// Nearest-neighbor integer upscaler for 24-bit RGB rows with a line store.
// ----------------------------------------------------------------------------
// Each request yields scale pixel results, followed at a row end by 0 to 3
// pad bytes, or one reject result for a request of the wrong phase. The
// result port moves one result per cycle while m_ready is high, and the
// output emitter counts down a request's pixel copies, then its pad bytes.
// Requests are taken back to back: one is held in a job register while the
// emitter works; the line store is read the cycle a replay request is taken.
// Configuration must be written only while the block is idle (not enforced).
module pixel_replicating_upscaler (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [pru_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [pru_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_operation,
    input  logic [7:0]                  s_red,
    input  logic [7:0]                  s_green,
    input  logic [7:0]                  s_blue,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pru_pkg::STAT_W-1:0]  m_status,
    output logic [7:0]                  m_out_red,
    output logic [7:0]                  m_out_green,
    output logic [7:0]                  m_out_blue,
    output logic                        m_row_end,
    output logic                        m_frame_end,
    output logic                        m_last
);
    import pru_pkg::*;

    logic [SCALE_W-1:0]  scale_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    logic [COL_W-1:0]    column_reg, column_next;
    logic [COPY_W-1:0]   copy_reg, copy_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic                replay_reg, replay_next;

    logic [RGB_W-1:0]    line_mem [MAX_WIDTH];
    logic [RGB_W-1:0]    rdata_reg;

    logic                job_valid_reg;
    job_t                job_reg, job_next;

    logic                em_valid_reg;
    logic                em_err_reg;
    logic [RGB_W-1:0]    em_rgb_reg;
    logic [SCALE_W-1:0]  em_pix_reg;
    logic [1:0]          em_pad_reg;
    logic                em_row_reg;
    logic                em_frame_reg;

    logic                accept, job_take, em_final;
    logic                wrong, row_done, frame_done;
    logic [WIDTH_W-1:0]  col_inc;
    logic [SCALE_W-1:0]  copy_inc;
    logic [HEIGHT_W-1:0] row_inc;
    logic                last_row;
    logic [3:0]          wprod;
    logic [1:0]          bytes_mod;
    logic [1:0]          pad;
    logic [RGB_W-1:0]    s_pixel;

    // configuration with saturation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg  <= SCALE_W'(1);
            width_reg  <= WIDTH_W'(1);
            height_reg <= HEIGHT_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SCALE: begin
                    if (cfg_data[SCALE_W-1:0] == '0)
                        scale_reg <= SCALE_W'(1);
                    else if (cfg_data[SCALE_W-1:0] > SCALE_W'(MAX_SCALE))
                        scale_reg <= SCALE_W'(MAX_SCALE);
                    else
                        scale_reg <= cfg_data[SCALE_W-1:0];
                end
                REG_WIDTH: begin
                    if (cfg_data[WIDTH_W-1:0] == '0)
                        width_reg <= WIDTH_W'(1);
                    else if (cfg_data[WIDTH_W-1:0] > WIDTH_W'(MAX_WIDTH))
                        width_reg <= WIDTH_W'(MAX_WIDTH);
                    else
                        width_reg <= cfg_data[WIDTH_W-1:0];
                end
                REG_HEIGHT: begin
                    if (cfg_data[HEIGHT_W-1:0] == '0)
                        height_reg <= HEIGHT_W'(1);
                    else if (cfg_data[HEIGHT_W-1:0] > HEIGHT_W'(MAX_HEIGHT))
                        height_reg <= HEIGHT_W'(MAX_HEIGHT);
                    else
                        height_reg <= cfg_data[HEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // handshake
    assign em_final = em_err_reg
                   || (em_pix_reg == SCALE_W'(1) && em_pad_reg == 2'd0)
                   || (em_pix_reg == '0 && em_pad_reg == 2'd1);
    assign job_take = job_valid_reg && (!em_valid_reg || (m_ready && em_final));
    assign s_ready  = !job_valid_reg || job_take;
    assign accept   = s_valid && s_ready;

    // request decode and state update
    assign s_pixel  = {s_red, s_green, s_blue};
    assign wrong    = (s_operation == OP_REPLAY) != replay_reg;
    assign col_inc  = WIDTH_W'(column_reg) + WIDTH_W'(1);
    assign row_done = col_inc >= width_reg;
    assign copy_inc = SCALE_W'(copy_reg) + SCALE_W'(1);
    assign row_inc  = HEIGHT_W'(row_reg) + HEIGHT_W'(1);
    assign last_row = row_inc >= height_reg;
    assign wprod    = {2'b00, width_reg[1:0]} * {2'b00, scale_reg[1:0]};
    assign bytes_mod = 2'(wprod * 4'd3);
    assign pad      = 2'(3'd4 - {1'b0, bytes_mod});

    always_comb begin
        column_next = column_reg;
        copy_next   = copy_reg;
        row_next    = row_reg;
        replay_next = replay_reg;
        frame_done  = 1'b0;
        if (!wrong) begin
            if (row_done) begin
                column_next = '0;
                if (!replay_reg) begin
                    if (scale_reg <= SCALE_W'(1)) begin
                        frame_done = last_row;
                        row_next   = last_row ? '0 : row_inc[ROW_W-1:0];
                    end else begin
                        copy_next   = COPY_W'(1);
                        replay_next = 1'b1;
                    end
                end else if (copy_inc >= scale_reg) begin
                    copy_next   = '0;
                    replay_next = 1'b0;
                    frame_done  = last_row;
                    row_next    = last_row ? '0 : row_inc[ROW_W-1:0];
                end else begin
                    copy_next = copy_inc[COPY_W-1:0];
                end
            end else begin
                column_next = col_inc[COL_W-1:0];
            end
        end
        job_next.err        = wrong;
        job_next.use_mem    = replay_reg;
        job_next.pixel      = s_pixel;
        job_next.copies     = scale_reg;
        job_next.pad        = row_done ? pad : 2'd0;
        job_next.row_done   = row_done;
        job_next.frame_done = frame_done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            copy_reg   <= '0;
            row_reg    <= '0;
            replay_reg <= 1'b0;
        end else if (accept) begin
            column_reg <= column_next;
            copy_reg   <= copy_next;
            row_reg    <= row_next;
            replay_reg <= replay_next;
        end
    end

    // line store
    always_ff @(posedge aclk) begin
        if (accept && !wrong && !replay_reg)
            line_mem[column_reg] <= s_pixel;
        if (accept && !wrong && replay_reg)
            rdata_reg <= line_mem[column_reg];
    end

    // job register
    always_ff @(posedge aclk) begin
        if (!aresetn)
            job_valid_reg <= 1'b0;
        else if (accept)
            job_valid_reg <= 1'b1;
        else if (job_take)
            job_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (accept)
            job_reg <= job_next;
    end

    // output emitter
    always_ff @(posedge aclk) begin
        if (!aresetn)
            em_valid_reg <= 1'b0;
        else if (job_take)
            em_valid_reg <= 1'b1;
        else if (m_ready && em_final)
            em_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (job_take) begin
            em_err_reg   <= job_reg.err;
            em_rgb_reg   <= job_reg.use_mem ? rdata_reg : job_reg.pixel;
            em_pix_reg   <= job_reg.copies;
            em_pad_reg   <= job_reg.pad;
            em_row_reg   <= job_reg.row_done;
            em_frame_reg <= job_reg.frame_done;
        end else if (em_valid_reg && m_ready && !em_final) begin
            if (em_pix_reg != '0)
                em_pix_reg <= em_pix_reg - SCALE_W'(1);
            else
                em_pad_reg <= em_pad_reg - 2'd1;
        end
    end

    always_comb begin
        m_valid     = em_valid_reg;
        m_status    = ST_PIXEL;
        m_out_red   = '0;
        m_out_green = '0;
        m_out_blue  = '0;
        m_row_end   = 1'b0;
        m_frame_end = 1'b0;
        m_last      = em_final;
        if (em_err_reg) begin
            m_status = ST_REJECT;
        end else begin
            if (em_pix_reg != '0) begin
                m_out_red   = em_rgb_reg[23:16];
                m_out_green = em_rgb_reg[15:8];
                m_out_blue  = em_rgb_reg[7:0];
            end else begin
                m_status = ST_PAD;
            end
            m_row_end   = em_final && em_row_reg;
            m_frame_end = em_final && em_frame_reg;
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest-neighbor pixel upscaler.
// ----------------------------------------------------------------------------
// Requests are queued by a stimulus process and driven with random gaps. The
// output side stalls at random. Every accepted request is run through a local
// copy of the upscaler's row and phase logic, and each result leaving the
// block is compared against the oldest predicted one. Directed cases cover
// padding of 1 to 3 bytes, wrong-phase rejects, register clamping and limits
// lowered in the middle of a row; random phases then mix settings and bad ops.
// ----------------------------------------------------------------------------
module tb_top;
    import pru_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic              row_end;
        logic              frame_end;
        logic              last;
    } upscaled_px_t;

    typedef struct packed {
        logic             op;
        logic [RGB_W-1:0] rgb;
    } pixel_req_t;

    typedef struct packed {
        int   column;
        int   copy_row;
        int   input_row;
        logic replaying;
        int   scale;
        int   width;
        int   height;
    } scaler_state_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_operation = OP_PIXEL;
    logic [7:0] s_red = '0;
    logic [7:0] s_green = '0;
    logic [7:0] s_blue = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [STAT_W-1:0] m_status;
    logic [7:0] m_out_red;
    logic [7:0] m_out_green;
    logic [7:0] m_out_blue;
    logic m_row_end;
    logic m_frame_end;
    logic m_last;

    pixel_req_t    pixel_req_q[$];
    upscaled_px_t  upscaled_q[$];
    logic [RGB_W-1:0] row_copy [MAX_WIDTH];
    scaler_state_t pred_st;
    scaler_state_t gen_st;
    logic req_taken = 1'b0;
    bit   calm = 1'b0;
    int   src_idle = 0;
    int   snk_stall = 0;
    int   mismatches = 0;
    int unsigned cycles = 0;

    pixel_replicating_upscaler uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_red       (s_red),
        .s_green     (s_green),
        .s_blue      (s_blue),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue),
        .m_row_end   (m_row_end),
        .m_frame_end (m_frame_end),
        .m_last      (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic scaler_state_t clamp_reg(input scaler_state_t st,
                                                input logic [CIDX_W-1:0] idx,
                                                input logic [CFG_W-1:0] val);
        int v;
        case (idx)
            REG_SCALE: begin
                v = int'(val[SCALE_W-1:0]);
                st.scale = (v == 0) ? 1 : (v > MAX_SCALE) ? MAX_SCALE : v;
            end
            REG_WIDTH: begin
                v = int'(val[WIDTH_W-1:0]);
                st.width = (v == 0) ? 1 : (v > MAX_WIDTH) ? MAX_WIDTH : v;
            end
            REG_HEIGHT: begin
                v = int'(val[HEIGHT_W-1:0]);
                st.height = (v == 0) ? 1 : (v > MAX_HEIGHT) ? MAX_HEIGHT : v;
            end
            default: ;
        endcase
        return st;
    endfunction

    function automatic bit bump_row(inout scaler_state_t st);
        if (st.input_row + 1 >= st.height) begin
            st.input_row = 0;
            return 1'b1;
        end
        st.input_row++;
        return 1'b0;
    endfunction

    // record=0 only advances phase state (used by the stimulus side)
    function automatic scaler_state_t upscale_step(input scaler_state_t st,
                                                   input logic op,
                                                   input logic [RGB_W-1:0] pixel,
                                                   input bit record);
        int idx;
        int pad;
        int n;
        logic row_done;
        logic frame_done;
        logic [RGB_W-1:0] rgb;
        upscaled_px_t r;
        idx = (st.column < MAX_WIDTH) ? st.column : MAX_WIDTH - 1;
        row_done = (st.column + 1 >= st.width);
        frame_done = 1'b0;
        rgb = pixel;
        if ((op == OP_REPLAY) != st.replaying) begin
            if (record) begin
                r = '0;
                r.status = ST_REJECT;
                r.last = 1'b1;
                upscaled_q.push_back(r);
            end
            return st;
        end
        if (st.replaying) begin
            if (record) rgb = row_copy[idx];
            if (row_done) begin
                st.column = 0;
                st.copy_row++;
                if (st.copy_row >= st.scale) begin
                    st.copy_row = 0;
                    st.replaying = 1'b0;
                    frame_done = bump_row(st);
                end
            end else begin
                st.column++;
            end
        end else begin
            if (record) row_copy[idx] = pixel;
            if (row_done) begin
                st.column = 0;
                if (st.scale <= 1) begin
                    frame_done = bump_row(st);
                end else begin
                    st.copy_row = 1;
                    st.replaying = 1'b1;
                end
            end else begin
                st.column++;
            end
        end
        if (record) begin
            pad = row_done ? (4 - (st.width * st.scale * 3) % 4) % 4 : 0;
            n = st.scale + pad;
            for (int i = 0; i < n; i++) begin
                r = '0;
                if (i < st.scale) begin
                    r.status = ST_PIXEL;
                    {r.red, r.green, r.blue} = rgb;
                end else begin
                    r.status = ST_PAD;
                end
                r.row_end = row_done && (i == n - 1);
                r.frame_end = frame_done && (i == n - 1);
                r.last = (i == n - 1);
                upscaled_q.push_back(r);
            end
        end
        return st;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // predict on request accept, then check any result leaving the block
    always @(posedge aclk) begin : watch
        upscaled_px_t want;
        cycles <= cycles + 1;
        req_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            pred_st = upscale_step(pred_st, s_operation, {s_red, s_green, s_blue}, 1'b1);
        end
        if (aresetn && m_valid && m_ready) begin
            if (upscaled_q.size() == 0) begin
                $error("result with no request pending: status %0d", m_status);
                mismatches++;
            end else begin
                want = upscaled_q.pop_front();
                check_field("status", 8'(want.status), 8'(m_status));
                check_field("out_red", want.red, m_out_red);
                check_field("out_green", want.green, m_out_green);
                check_field("out_blue", want.blue, m_out_blue);
                check_field("row_end", 8'(want.row_end), 8'(m_row_end));
                check_field("frame_end", 8'(want.frame_end), 8'(m_frame_end));
                check_field("last", 8'(want.last), 8'(m_last));
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge aclk) begin : drive_req
        pixel_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !req_taken) begin
            // hold until accepted
        end else if (src_idle > 0) begin
            src_idle <= src_idle - 1;
            s_valid <= 1'b0;
        end else if (pixel_req_q.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
            src_idle <= $urandom_range(0, 10);
            s_valid <= 1'b0;
        end else if (pixel_req_q.size() != 0) begin
            nxt = pixel_req_q.pop_front();
            s_valid <= 1'b1;
            s_operation <= nxt.op;
            {s_red, s_green, s_blue} <= nxt.rgb;
        end else begin
            s_valid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (snk_stall > 0) begin
            snk_stall <= snk_stall - 1;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            snk_stall <= $urandom_range(0, 10);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        gen_st = clamp_reg(gen_st, idx, val);
        pred_st = clamp_reg(pred_st, idx, val);
    endtask

    task automatic add_req(input logic op, input logic [RGB_W-1:0] rgb);
        pixel_req_t it;
        it.op = op;
        it.rgb = rgb;
        gen_st = upscale_step(gen_st, op, rgb, 1'b0);
        pixel_req_q.push_back(it);
    endtask

    task automatic drain;
        do @(posedge aclk);
        while (pixel_req_q.size() != 0 || s_valid || upscaled_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // well-formed ops follow the phase; noise_pct percent are flipped
    task automatic run_reqs(input int n, input int noise_pct);
        logic op;
        for (int i = 0; i < n; i++) begin
            op = gen_st.replaying ? OP_REPLAY : OP_PIXEL;
            if ($urandom_range(1, 100) <= noise_pct) op = ~op;
            add_req(op, RGB_W'($urandom()));
        end
        drain();
    endtask

    initial begin
        int randomized;
        int n;
        pred_st = '{column: 0, copy_row: 0, input_row: 0, replaying: 1'b0,
                    scale: 1, width: 1, height: 1};
        gen_st = pred_st;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: one pixel per row, pad of one byte
        add_req(OP_PIXEL, 24'hFFFFFF);
        add_req(OP_PIXEL, 24'h000000);
        add_req(OP_REPLAY, 24'h000000);
        drain();

        // scale 3: pad of three, rejects in both phases
        write_reg(REG_SCALE, 13'd3);
        write_reg(REG_HEIGHT, 13'd1);
        add_req(OP_REPLAY, 24'h123456);
        add_req(OP_PIXEL, 24'hA5A5A5);
        add_req(OP_PIXEL, 24'h5A5A5A);
        add_req(OP_REPLAY, 24'h000000);
        add_req(OP_REPLAY, 24'hFFFFFF);
        drain();

        // zero scale taken as one, pad of two
        write_reg(REG_SCALE, 13'd0);
        write_reg(REG_WIDTH, 13'd2);
        run_reqs(2, 0);

        // limits lowered mid-row and mid-frame
        write_reg(REG_SCALE, 13'd4);
        write_reg(REG_WIDTH, 13'd3);
        write_reg(REG_HEIGHT, 13'd3);
        run_reqs(5, 0);
        write_reg(REG_SCALE, 13'd2);
        write_reg(REG_WIDTH, 13'd1);
        run_reqs(1, 0);
        write_reg(REG_HEIGHT, 13'd1);
        run_reqs(2, 0);

        // width and height clamped, row cut short
        write_reg(REG_SCALE, 13'd1);
        write_reg(REG_WIDTH, 13'd2047);
        write_reg(REG_HEIGHT, 13'd8191);
        run_reqs(4, 0);
        write_reg(REG_WIDTH, 13'd1);
        write_reg(REG_HEIGHT, 13'd1);
        run_reqs(2, 0);

        randomized = 0;
        while (randomized < 320) begin
            if (randomized >= 265) calm = 1'b1;
            if ($urandom_range(0, 2) == 0) begin
                write_reg(REG_SCALE, ($urandom_range(0, 3) == 0) ?
                          CFG_W'($urandom()) : CFG_W'($urandom_range(1, 4)));
            end
            // width may grow only outside replay
            if (!gen_st.replaying && $urandom_range(0, 2) == 0) begin
                write_reg(REG_WIDTH, ($urandom_range(0, 11) == 0) ?
                          CFG_W'($urandom()) : CFG_W'($urandom_range(1, 6)));
            end
            if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_HEIGHT, ($urandom_range(0, 7) == 0) ?
                          CFG_W'($urandom()) : CFG_W'($urandom_range(1, 3)));
            end
            n = $urandom_range(15, 45);
            run_reqs(n, 8);
            randomized += n;
        end

        drain();
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/pru_pkg.sv
hw/rtl/pixel_replicating_upscaler.sv
tb/tb_top.sv
